### src/mips_ie_pkg.sv
// Shared types, opcodes and defaults for the MIPS I-type execute block.
package mips_ie_pkg;

  parameter int unsigned MEM_BYTES_DEF = 32'd65536;

  typedef enum logic [5:0] {
    OP_BEQ   = 6'h04,
    OP_BNE   = 6'h05,
    OP_ADDI  = 6'h08,
    OP_ADDIU = 6'h09,
    OP_SLTI  = 6'h0A,
    OP_SLTIU = 6'h0B,
    OP_ANDI  = 6'h0C,
    OP_ORI   = 6'h0D,
    OP_XORI  = 6'h0E,
    OP_LUI   = 6'h0F,
    OP_LB    = 6'h20,
    OP_LH    = 6'h21,
    OP_LW    = 6'h23,
    OP_LBU   = 6'h24,
    OP_LHU   = 6'h25,
    OP_SB    = 6'h28,
    OP_SH    = 6'h29,
    OP_SW    = 6'h2B
  } opcode_e;

  typedef enum logic [2:0] {
    LD_NONE = 3'd0,
    LD_B    = 3'd1,
    LD_BU   = 3'd2,
    LD_H    = 3'd3,
    LD_HU   = 3'd4,
    LD_W    = 3'd5
  } load_e;

  // Register file write port
  typedef struct packed {
    logic        we;
    logic [4:0]  addr;
    logic [31:0] data;
  } rf_wr_t;

  // Data memory strobe and per-lane write mask (lane 0 is the lowest byte)
  typedef struct packed {
    logic       en;
    logic [3:0] wmask;
  } dmem_ctl_t;

endpackage

### src/mips_ie_if.sv
// Valid/ready channel interfaces for instructions in and results out.
interface mips_ie_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic [31:0] cur_pc;

  modport source (output valid, output instr_word, output cur_pc, input ready);
  modport sink (input valid, input instr_word, input cur_pc, output ready);
endinterface

interface mips_ie_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        branch_taken;
  logic        reg_write;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic        unknown_op;

  modport source (output valid, output next_pc, output branch_taken, output reg_write,
                  output reg_index, output reg_value, output unknown_op, input ready);
  modport sink (input valid, input next_pc, input branch_taken, input reg_write,
                input reg_index, input reg_value, input unknown_op, output ready);
endinterface

### src/mips_ie_regfile.sv
// 32 x 32-bit register file with registered dual read and per-entry valid bits.
module mips_ie_regfile (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mips_ie_pkg::rf_wr_t wr_i,
  input  logic                rd_en_i,
  input  logic [4:0]          rs_i,
  input  logic [4:0]          rt_i,
  output logic [31:0]         rd_a_o,
  output logic [31:0]         rd_b_o
);

  logic [31:0] rf_q [32];
  logic [31:0] valid_q;
  logic [31:0] rd_a_q, rd_b_q;
  logic        rd_av_q, rd_bv_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      rf_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_a_q <= rf_q[rs_i];
      rd_b_q <= rf_q[rt_i];
    end
  end

  // An entry never written reads as zero; entry zero is never written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_av_q <= 1'b0;
      rd_bv_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_av_q <= valid_q[rs_i];
        rd_bv_q <= valid_q[rt_i];
      end
    end
  end

  assign rd_a_o = rd_av_q ? rd_a_q : '0;
  assign rd_b_o = rd_bv_q ? rd_b_q : '0;

endmodule

### src/mips_ie_dmem.sv
// Byte-addressed little-endian data memory in four byte banks, unaligned access.
module mips_ie_dmem #(
  parameter int unsigned MemBytes = mips_ie_pkg::MEM_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic [$clog2(MemBytes)-1:0]      addr_i,
  input  mips_ie_pkg::dmem_ctl_t           ctl_i,
  input  logic [31:0]                      wdata_i,
  output logic [31:0]                      rdata_o
);

  localparam int unsigned AddrW = $clog2(MemBytes);
  localparam int unsigned Rows  = MemBytes / 4;

  logic [3:0][7:0] wbytes;
  logic [3:0][7:0] bank_rd;
  logic [3:0][7:0] rbytes;
  logic [1:0]      ofs_q;

  assign wbytes = wdata_i;

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]       mem_q [Rows];
    logic [7:0]       rd_q;
    logic [1:0]       lane;
    logic [AddrW-1:0] baddr;

    // Lane of the access that lands in this bank, and its wrapped byte address
    assign lane  = 2'(k) - addr_i[1:0];
    assign baddr = addr_i + AddrW'(lane);

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        if (ctl_i.wmask[lane]) begin
          mem_q[baddr[AddrW-1:2]] <= wbytes[lane];
        end
        rd_q <= mem_q[baddr[AddrW-1:2]];
      end
    end

    assign bank_rd[k] = rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      ofs_q <= addr_i[1:0];
    end
  end

  // Rotate bank order back into lane order
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rbytes[i] = bank_rd[2'(ofs_q + 2'(i))];
    end
  end

  assign rdata_o = rbytes;

endmodule

### src/mips_itype_execute_top.sv
// Top level of the MIPS32 I-type execute block.
//
// Instructions arrive on in_i (instr_word, cur_pc) and results leave on out_o
// (next_pc, branch_taken, reg_write, reg_index, reg_value, unknown_op), both as
// valid/ready channels; a transfer happens when valid and ready are both high.
// Each instruction gives exactly one result, in order.
// After an input transfer, registers are read at the transfer, then execute and
// memory access, then load alignment and write-back into the output register,
// which raises out_o.valid. One instruction is accepted per cycle while the
// pipeline is not stalled; dependent instructions follow back to back through
// forwarding from the write-back stage.
// Register writes take effect as an instruction leaves the alignment stage;
// stores write memory as they leave the execute stage.
// MemBytes must be a power of two; addresses wrap modulo MemBytes.
// Reset empties the pipeline and makes every register read as zero; memory
// content is undefined until written, and no clearing pass is run.
// When the receiver stalls the result is held in the output register and the
// earlier stages keep filling until all three are occupied, then in_i.ready
// drops.
module mips_itype_execute_top #(
  parameter int unsigned MemBytes = mips_ie_pkg::MEM_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  mips_ie_in_if.sink      in_i,
  mips_ie_out_if.source   out_o
);

  localparam int unsigned AddrW = $clog2(MemBytes);

  logic in_xfer, s1_move, s2_move;

  // Execute stage
  logic        s1_valid_q;
  logic [31:0] s1_instr_q, s1_pc_q;

  // Alignment stage
  logic                 s2_valid_q, s2_wr_q, s2_taken_q, s2_unk_q;
  logic [4:0]           s2_rt_q;
  logic [31:0]          s2_alu_q, s2_npc_q;
  mips_ie_pkg::load_e   s2_ld_q;
  logic [31:0]          s2_val;

  // Output register
  logic        out_valid_q, out_wr_q, out_taken_q, out_unk_q;
  logic [4:0]  out_rt_q;
  logic [31:0] out_val_q, out_npc_q;

  // Operand overrides for writes that land while an instruction waits in s1
  logic        ovr_a_q, ovr_a_d, ovr_b_q, ovr_b_d;
  logic [31:0] ovr_a_val_q, ovr_a_val_d, ovr_b_val_q, ovr_b_val_d;

  mips_ie_pkg::rf_wr_t    rf_wr;
  mips_ie_pkg::dmem_ctl_t dm_ctl;
  logic [31:0]            rf_rd_a, rf_rd_b, dm_rdata;

  mips_ie_pkg::opcode_e s1_op;
  mips_ie_pkg::load_e   s1_ld;
  logic [4:0]           s1_rs, s1_rt;
  logic [15:0]          s1_imm;
  logic [31:0]          s1_simm, s1_zimm, op_a, op_b, s1_ea, s1_val, s1_npc, pc_plus4;
  logic                 s1_wr, s1_taken, s1_unk, fwd_a, fwd_b;
  logic [3:0]           st_mask;

  assign s2_move    = s2_valid_q && (!out_valid_q || out_o.ready);
  assign s1_move    = s1_valid_q && (!s2_valid_q || s2_move);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_xfer    = in_i.valid && in_i.ready;

  assign rf_wr.we   = s2_move && s2_wr_q && (s2_rt_q != '0);
  assign rf_wr.addr = s2_rt_q;
  assign rf_wr.data = s2_val;

  mips_ie_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (rf_wr),
    .rd_en_i (in_xfer),
    .rs_i    (in_i.instr_word[25:21]),
    .rt_i    (in_i.instr_word[20:16]),
    .rd_a_o  (rf_rd_a),
    .rd_b_o  (rf_rd_b)
  );

  // ---------------- execute stage ----------------
  assign s1_op   = mips_ie_pkg::opcode_e'(s1_instr_q[31:26]);
  assign s1_rs   = s1_instr_q[25:21];
  assign s1_rt   = s1_instr_q[20:16];
  assign s1_imm  = s1_instr_q[15:0];
  assign s1_simm = {{16{s1_imm[15]}}, s1_imm};
  assign s1_zimm = {16'h0000, s1_imm};

  // The alignment stage holds the only older instruction not yet written back
  assign fwd_a = s2_valid_q && s2_wr_q && (s2_rt_q == s1_rs) && (s1_rs != '0);
  assign fwd_b = s2_valid_q && s2_wr_q && (s2_rt_q == s1_rt) && (s1_rt != '0);
  assign op_a  = fwd_a ? s2_val : (ovr_a_q ? ovr_a_val_q : rf_rd_a);
  assign op_b  = fwd_b ? s2_val : (ovr_b_q ? ovr_b_val_q : rf_rd_b);

  assign s1_ea    = op_a + s1_simm;
  assign pc_plus4 = s1_pc_q + 32'd4;
  assign s1_npc   = s1_taken ? pc_plus4 + {s1_simm[29:0], 2'b00} : pc_plus4;

  always_comb begin
    s1_wr    = 1'b0;
    s1_val   = '0;
    s1_taken = 1'b0;
    s1_unk   = 1'b0;
    s1_ld    = mips_ie_pkg::LD_NONE;
    st_mask  = 4'b0000;
    case (s1_op)
      mips_ie_pkg::OP_ADDI, mips_ie_pkg::OP_ADDIU: begin
        s1_wr  = 1'b1;
        s1_val = s1_ea;
      end
      mips_ie_pkg::OP_SLTI: begin
        s1_wr  = 1'b1;
        s1_val = {31'd0, $signed(op_a) < $signed(s1_simm)};
      end
      mips_ie_pkg::OP_SLTIU: begin
        s1_wr  = 1'b1;
        s1_val = {31'd0, op_a < s1_simm};
      end
      mips_ie_pkg::OP_ANDI: begin
        s1_wr  = 1'b1;
        s1_val = op_a & s1_zimm;
      end
      mips_ie_pkg::OP_ORI: begin
        s1_wr  = 1'b1;
        s1_val = op_a | s1_zimm;
      end
      mips_ie_pkg::OP_XORI: begin
        s1_wr  = 1'b1;
        s1_val = op_a ^ s1_zimm;
      end
      mips_ie_pkg::OP_LUI: begin
        s1_wr  = 1'b1;
        s1_val = {s1_imm, 16'h0000};
      end
      mips_ie_pkg::OP_LB: begin
        s1_wr = 1'b1;
        s1_ld = mips_ie_pkg::LD_B;
      end
      mips_ie_pkg::OP_LBU: begin
        s1_wr = 1'b1;
        s1_ld = mips_ie_pkg::LD_BU;
      end
      mips_ie_pkg::OP_LH: begin
        s1_wr = 1'b1;
        s1_ld = mips_ie_pkg::LD_H;
      end
      mips_ie_pkg::OP_LHU: begin
        s1_wr = 1'b1;
        s1_ld = mips_ie_pkg::LD_HU;
      end
      mips_ie_pkg::OP_LW: begin
        s1_wr = 1'b1;
        s1_ld = mips_ie_pkg::LD_W;
      end
      mips_ie_pkg::OP_SB:  st_mask = 4'b0001;
      mips_ie_pkg::OP_SH:  st_mask = 4'b0011;
      mips_ie_pkg::OP_SW:  st_mask = 4'b1111;
      mips_ie_pkg::OP_BEQ: s1_taken = (op_a == op_b);
      mips_ie_pkg::OP_BNE: s1_taken = (op_a != op_b);
      default:             s1_unk = 1'b1;
    endcase
  end

  assign dm_ctl.en    = s1_move && ((s1_ld != mips_ie_pkg::LD_NONE) || (st_mask != 4'b0000));
  assign dm_ctl.wmask = st_mask;

  mips_ie_dmem #(
    .MemBytes (MemBytes)
  ) u_dmem (
    .clk_i   (clk_i),
    .addr_i  (s1_ea[AddrW-1:0]),
    .ctl_i   (dm_ctl),
    .wdata_i (op_b),
    .rdata_o (dm_rdata)
  );

  // ---------------- alignment stage ----------------
  always_comb begin
    case (s2_ld_q)
      mips_ie_pkg::LD_B:  s2_val = {{24{dm_rdata[7]}}, dm_rdata[7:0]};
      mips_ie_pkg::LD_BU: s2_val = {24'd0, dm_rdata[7:0]};
      mips_ie_pkg::LD_H:  s2_val = {{16{dm_rdata[15]}}, dm_rdata[15:0]};
      mips_ie_pkg::LD_HU: s2_val = {16'd0, dm_rdata[15:0]};
      mips_ie_pkg::LD_W:  s2_val = dm_rdata;
      default:            s2_val = s2_alu_q;
    endcase
  end

  // ---------------- operand overrides ----------------
  always_comb begin
    ovr_a_d     = ovr_a_q;
    ovr_a_val_d = ovr_a_val_q;
    ovr_b_d     = ovr_b_q;
    ovr_b_val_d = ovr_b_val_q;
    if (in_xfer) begin
      // The register read misses a write at this same edge
      ovr_a_d     = rf_wr.we && (rf_wr.addr == in_i.instr_word[25:21]);
      ovr_b_d     = rf_wr.we && (rf_wr.addr == in_i.instr_word[20:16]);
      ovr_a_val_d = rf_wr.data;
      ovr_b_val_d = rf_wr.data;
    end else if (s1_valid_q && rf_wr.we) begin
      if (rf_wr.addr == s1_rs) begin
        ovr_a_d     = 1'b1;
        ovr_a_val_d = rf_wr.data;
      end
      if (rf_wr.addr == s1_rt) begin
        ovr_b_d     = 1'b1;
        ovr_b_val_d = rf_wr.data;
      end
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ovr_a_q     <= 1'b0;
      ovr_b_q     <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        s2_valid_q <= 1'b1;
      end else if (s2_move) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      ovr_a_q <= ovr_a_d;
      ovr_b_q <= ovr_b_d;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    ovr_a_val_q <= ovr_a_val_d;
    ovr_b_val_q <= ovr_b_val_d;
    if (in_xfer) begin
      s1_instr_q <= in_i.instr_word;
      s1_pc_q    <= in_i.cur_pc;
    end
    if (s1_move) begin
      s2_wr_q    <= s1_wr;
      s2_rt_q    <= s1_rt;
      s2_alu_q   <= s1_val;
      s2_npc_q   <= s1_npc;
      s2_taken_q <= s1_taken;
      s2_unk_q   <= s1_unk;
      s2_ld_q    <= s1_ld;
    end
    if (s2_move) begin
      out_wr_q    <= s2_wr_q;
      out_rt_q    <= s2_rt_q;
      out_val_q   <= s2_val;
      out_npc_q   <= s2_npc_q;
      out_taken_q <= s2_taken_q;
      out_unk_q   <= s2_unk_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.next_pc      = out_npc_q;
  assign out_o.branch_taken = out_taken_q;
  assign out_o.reg_write    = out_wr_q;
  assign out_o.reg_index    = out_rt_q;
  assign out_o.reg_value    = out_val_q;
  assign out_o.unknown_op   = out_unk_q;

  // ---------------- assertions ----------------
  a_no_write_r0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.we |-> rf_wr.addr != 5'd0)
    else $error("write-back to register zero");

  a_unknown_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_unk_q) |-> (!out_wr_q && !out_taken_q && out_val_q == 32'd0))
    else $error("unknown opcode result has side fields set");

  a_branch_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_taken_q) |-> !out_wr_q)
    else $error("taken branch also writes a register");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |-> (s2_valid_q && !s2_move && out_valid_q))
    else $error("execute stage held while downstream has room");

  a_s2_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_move |=> out_valid_q)
    else $error("result lost between alignment stage and output");

endmodule
